FILE: rtl/swd_pkg.sv
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types, constants and helpers for the sync word feedback deframer.
// ----------------------------------------------------------------------------
package swd_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 3;
   localparam int CSR_W   = 1;

   localparam logic [WORD_W-1:0] SYNC_WORD_RESET  = 32'hA5CA_FEA5;
   localparam logic [WORD_W-1:0] FOLD_THR_RESET   = 32'h0001_2000;
   localparam logic [WORD_W-1:0] SENTINEL_UNSET   = 32'd200000;
   localparam logic [WORD_W-1:0] HOLD_AFTER_USE   = 32'd100000;
   localparam logic [WORD_W-1:0] HELD_RESET       = 32'd2;

   localparam logic [COUNT_W-1:0] POSITION_DONE = 3'd4;
   localparam logic [COUNT_W-1:0] INDEX_DONE    = 3'd0;

   typedef enum logic [CSR_W-1:0] {
      CSR_SYNC_WORD      = 1'b0,
      CSR_FOLD_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_POSITION = 1'b0,
      KIND_INDEX    = 1'b1
   } field_kind_type;

   typedef struct packed {
      logic                valid;
      field_kind_type      kind;
      logic [WORD_W-1:0]   raw;
      logic [WORD_W-1:0]   prev;
   } word_event_type;

   function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] v,
                                                    input logic [WORD_W-1:0] thr);
      return (v > thr) ? (WORD_W'(0) - v) : v;
   endfunction

endpackage

FILE: rtl/swd_req_if.sv
// ----------------------------------------------------------------------------
// swd_req_if
// Input byte channel: one received byte per beat.
// ----------------------------------------------------------------------------
interface swd_req_if import swd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/swd_rsp_if.sv
// ----------------------------------------------------------------------------
// swd_rsp_if
// Result channel: one completed payload word per beat.
// ----------------------------------------------------------------------------
interface swd_rsp_if import swd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     field_kind;
   logic [WORD_W-1:0]        raw_value;
   logic signed [WORD_W-1:0] folded_value;
   logic [WORD_W-1:0]        previous_value;
   logic signed [WORD_W-1:0] index_change;

   modport source (output valid, output field_kind, output raw_value,
                   output folded_value, output previous_value,
                   output index_change, input ready);
   modport sink   (input valid, input field_kind, input raw_value,
                   input folded_value, input previous_value,
                   input index_change, output ready);
endinterface

FILE: rtl/swd_csr_if.sv
// ----------------------------------------------------------------------------
// swd_csr_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface swd_csr_if import swd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CSR_W-1:0]  index;
   logic [WORD_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sync_word_feedback_deframer.sv
// ----------------------------------------------------------------------------
// sync_word_feedback_deframer
// Hunts for the sync word, assembles position and index words and reports
// each word with its folded value, previous value and signed index change.
// Throughput: one byte per cycle; the byte path stalls only when the
// four-deep result pipeline is full and the result side is not taking beats.
// A completed word passes through the s1, s2, s3 and output registers before its result is valid.
// Reset: synchronous; clears the hunt window, counters, pipeline valids and
// restores the register defaults.
// ----------------------------------------------------------------------------
module sync_word_feedback_deframer import swd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   swd_req_if.sink      req_bus,
   swd_rsp_if.source    rsp_bus,
   swd_csr_if.sink      csr_bus
);

   logic [WORD_W-1:0] sync_word_ff;
   logic [WORD_W-1:0] fold_thr_ff;

   word_event_type    word_event;
   logic              req_beat;

   logic              s1_valid_ff;
   field_kind_type    s1_kind_ff;
   logic [WORD_W-1:0] s1_raw_ff, s1_prev_ff;

   logic              s2_valid_ff;
   field_kind_type    s2_kind_ff;
   logic [WORD_W-1:0] s2_raw_ff, s2_prev_ff, s2_fc_ff, s2_fp_ff;

   logic              s3_valid_ff;
   field_kind_type    s3_kind_ff;
   logic [WORD_W-1:0] s3_raw_ff, s3_prev_ff, s3_fc_ff, s3_diff_ff;
   logic              s3_less_ff;

   logic              out_valid_ff;
   field_kind_type    out_kind_ff;
   logic [WORD_W-1:0] out_raw_ff, out_prev_ff, out_fc_ff, out_change_ff;

   logic              ready_out, ready_s3, ready_s2, ready_s1;
   logic [WORD_W-1:0] change_in;

   assign ready_out = !out_valid_ff || rsp_bus.ready;
   assign ready_s3  = !s3_valid_ff || ready_out;
   assign ready_s2  = !s2_valid_ff || ready_s3;
   assign ready_s1  = !s1_valid_ff || ready_s2;

   assign req_bus.ready = ready_s1;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= SYNC_WORD_RESET;
         fold_thr_ff  <= FOLD_THR_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_SYNC_WORD:      sync_word_ff <= csr_bus.data;
            CSR_FOLD_THRESHOLD: fold_thr_ff  <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   swd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .beat       (req_beat),
      .rx_byte    (req_bus.rx_byte),
      .sync_word  (sync_word_ff),
      .word_event (word_event)
   );

   always_comb begin
      if (s3_kind_ff == KIND_INDEX) begin
         change_in = (s3_diff_ff[WORD_W-1] ^ s3_less_ff) ? (WORD_W'(0) - s3_diff_ff)
                                                          : s3_diff_ff;
      end else begin
         change_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready_s1) s1_valid_ff <= word_event.valid;
         if (ready_s2) s2_valid_ff <= s1_valid_ff;
         if (ready_s3) s3_valid_ff <= s2_valid_ff;
         if (ready_out) out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_s1) begin
         s1_kind_ff <= word_event.kind;
         s1_raw_ff  <= word_event.raw;
         s1_prev_ff <= word_event.prev;
      end
      if (ready_s2) begin
         s2_kind_ff <= s1_kind_ff;
         s2_raw_ff  <= s1_raw_ff;
         s2_prev_ff <= s1_prev_ff;
         s2_fc_ff   <= fold_word(s1_raw_ff, fold_thr_ff);
         s2_fp_ff   <= fold_word(s1_prev_ff, fold_thr_ff);
      end
      if (ready_s3) begin
         s3_kind_ff <= s2_kind_ff;
         s3_raw_ff  <= s2_raw_ff;
         s3_prev_ff <= s2_prev_ff;
         s3_fc_ff   <= s2_fc_ff;
         s3_diff_ff <= s2_fc_ff - s2_fp_ff;
         s3_less_ff <= s2_fc_ff < s2_fp_ff;
      end
      if (ready_out) begin
         out_kind_ff   <= s3_kind_ff;
         out_raw_ff    <= s3_raw_ff;
         out_prev_ff   <= s3_prev_ff;
         out_fc_ff     <= s3_fc_ff;
         out_change_ff <= change_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.field_kind     = out_kind_ff;
   assign rsp_bus.raw_value      = out_raw_ff;
   assign rsp_bus.folded_value   = out_fc_ff;
   assign rsp_bus.previous_value = out_prev_ff;
   assign rsp_bus.index_change   = out_change_ff;

`ifndef SYNTHESIS
   a_position_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.field_kind == KIND_POSITION) |-> rsp_bus.index_change == '0)
      else $error("position result carries a nonzero index change");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && out_valid_ff && !rsp_bus.ready
      |-> !req_bus.ready)
      else $error("input taken while result pipeline is full and stalled");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_bus.ready |=> out_valid_ff && $stable(out_raw_ff)
      && $stable(out_change_ff))
      else $error("stalled result changed");
`endif

endmodule

FILE: rtl/swd_frame.sv
// ----------------------------------------------------------------------------
// swd_frame
// Sync hunt, payload word assembly and current/last value tracking.
// ----------------------------------------------------------------------------
module swd_frame import swd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [WORD_W-1:0] sync_word,
   output word_event_type    word_event
);

   logic [WORD_W-1:0]  hunt_ff, hunt_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  asm_ff, asm_in;
   logic [WORD_W-1:0]  cur_pos_ff, cur_pos_in;
   logic [WORD_W-1:0]  last_pos_ff, last_pos_in;
   logic [WORD_W-1:0]  cur_idx_ff, cur_idx_in;
   logic [WORD_W-1:0]  last_idx_ff, last_idx_in;
   logic [WORD_W-1:0]  held_ff, held_in;

   logic [WORD_W-1:0]  word;
   logic [COUNT_W-1:0] count_next;
   logic [WORD_W-1:0]  held_pos;
   logic [WORD_W-1:0]  held_idx;

   assign word       = {asm_ff[WORD_W-BYTE_W-1:0], rx_byte};
   assign count_next = count_ff + COUNT_W'(1);
   assign held_pos   = (cur_pos_ff != SENTINEL_UNSET) ? cur_pos_ff : held_ff;
   assign held_idx   = (cur_idx_ff != SENTINEL_UNSET) ? cur_idx_ff : held_ff;

   always_comb begin
      hunt_in     = hunt_ff;
      count_in    = count_ff;
      asm_in      = asm_ff;
      cur_pos_in  = cur_pos_ff;
      last_pos_in = last_pos_ff;
      cur_idx_in  = cur_idx_ff;
      last_idx_in = last_idx_ff;
      held_in     = held_ff;
      word_event  = '{valid: 1'b0, kind: KIND_POSITION, raw: word, prev: held_pos};
      if (beat) begin
         if (hunt_ff != sync_word) begin
            hunt_in = {hunt_ff[WORD_W-BYTE_W-1:0], rx_byte};
         end else begin
            asm_in   = word;
            count_in = count_next;
            case (count_next)
               POSITION_DONE: begin
                  cur_pos_in       = word;
                  last_pos_in      = held_pos;
                  held_in          = HOLD_AFTER_USE;
                  asm_in           = '0;
                  word_event.valid = 1'b1;
                  word_event.kind  = KIND_POSITION;
                  word_event.prev  = held_pos;
               end
               INDEX_DONE: begin
                  cur_idx_in       = word;
                  last_idx_in      = held_idx;
                  held_in          = HOLD_AFTER_USE;
                  asm_in           = '0;
                  hunt_in          = '0;
                  word_event.valid = 1'b1;
                  word_event.kind  = KIND_INDEX;
                  word_event.prev  = held_idx;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_ff     <= '0;
         count_ff    <= '0;
         asm_ff      <= '0;
         cur_pos_ff  <= SENTINEL_UNSET;
         last_pos_ff <= '0;
         cur_idx_ff  <= SENTINEL_UNSET;
         last_idx_ff <= '0;
         held_ff     <= HELD_RESET;
      end else begin
         hunt_ff     <= hunt_in;
         count_ff    <= count_in;
         asm_ff      <= asm_in;
         cur_pos_ff  <= cur_pos_in;
         last_pos_ff <= last_pos_in;
         cur_idx_ff  <= cur_idx_in;
         last_idx_ff <= last_idx_in;
         held_ff     <= held_in;
      end
   end

endmodule

FILE: tb/deframer_check_pkg.sv
// ----------------------------------------------------------------------------
// deframer_check_pkg
// Word scoreboard for the sync word feedback deframer: tracks hunt window,
// payload assembly and the shared hold register for every accepted byte, and
// matches each reported word against the oldest predicted one.
// ----------------------------------------------------------------------------
package deframer_check_pkg;
   import swd_pkg::*;

   typedef struct packed {
      field_kind_type           kind;
      logic [WORD_W-1:0]        raw;
      logic signed [WORD_W-1:0] folded;
      logic [WORD_W-1:0]        prev;
      logic signed [WORD_W-1:0] change;
   } word_report_type;

   class word_scoreboard;
      logic [WORD_W-1:0]  sync_word;
      logic [WORD_W-1:0]  fold_threshold;
      logic [WORD_W-1:0]  hunt_window;
      logic [COUNT_W-1:0] byte_count;
      logic [WORD_W-1:0]  word_assembly;
      logic [WORD_W-1:0]  position_now;
      logic [WORD_W-1:0]  position_last;
      logic [WORD_W-1:0]  index_now;
      logic [WORD_W-1:0]  index_last;
      logic [WORD_W-1:0]  held_previous;
      word_report_type    expected_words[$];
      int unsigned        mismatches;

      function new();
         sync_word      = SYNC_WORD_RESET;
         fold_threshold = FOLD_THR_RESET;
         hunt_window    = '0;
         byte_count     = '0;
         word_assembly  = '0;
         position_now   = SENTINEL_UNSET;
         position_last  = '0;
         index_now      = SENTINEL_UNSET;
         index_last     = '0;
         held_previous  = HELD_RESET;
         mismatches     = 0;
      endfunction

      function void write_register(csr_index_type index, logic [WORD_W-1:0] value);
         case (index)
            CSR_SYNC_WORD:      sync_word = value;
            CSR_FOLD_THRESHOLD: fold_threshold = value;
            default: ;
         endcase
      endfunction

      function logic [WORD_W-1:0] fold(logic [WORD_W-1:0] value);
         return (value > fold_threshold) ? (WORD_W'(0) - value) : value;
      endfunction

      function logic [WORD_W-1:0] index_delta(logic [WORD_W-1:0] fp, logic [WORD_W-1:0] fc);
         logic [WORD_W-1:0] diff;
         logic [WORD_W-1:0] mag;
         diff = fc - fp;
         mag  = diff[WORD_W-1] ? (WORD_W'(0) - diff) : diff;
         return (fc < fp) ? (WORD_W'(0) - mag) : mag;
      endfunction

      // Return the new last value; the hold register is shared by both pairs.
      function logic [WORD_W-1:0] hand_over(inout logic [WORD_W-1:0] current,
                                            input logic [WORD_W-1:0] word);
         logic [WORD_W-1:0] last;
         if (current != SENTINEL_UNSET)
            held_previous = current;
         current       = word;
         last          = held_previous;
         held_previous = HOLD_AFTER_USE;
         return last;
      endfunction

      function void note_rx_byte(logic [BYTE_W-1:0] rx_byte);
         word_report_type w;
         if (hunt_window != sync_word) begin
            hunt_window = {hunt_window[WORD_W-BYTE_W-1:0], rx_byte};
            return;
         end
         word_assembly = {word_assembly[WORD_W-BYTE_W-1:0], rx_byte};
         byte_count    = byte_count + 1'b1;
         if (byte_count == POSITION_DONE) begin
            position_last = hand_over(position_now, word_assembly);
            w.kind   = KIND_POSITION;
            w.raw    = word_assembly;
            w.folded = fold(word_assembly);
            w.prev   = position_last;
            w.change = '0;
            word_assembly = '0;
            expected_words.push_back(w);
         end else if (byte_count == INDEX_DONE) begin
            index_last = hand_over(index_now, word_assembly);
            w.kind   = KIND_INDEX;
            w.raw    = word_assembly;
            w.folded = fold(word_assembly);
            w.prev   = index_last;
            w.change = index_delta(fold(index_last), fold(index_now));
            word_assembly = '0;
            hunt_window   = '0;
            expected_words.push_back(w);
         end
      endfunction

      function void check_word(word_report_type got);
         word_report_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: kind=%0d raw=%h folded=%h prev=%h change=%h",
                        got.kind, got.raw, got.folded, got.prev, got.change);
            return;
         end
         want = expected_words.pop_front();
         if (got.kind !== want.kind || got.raw !== want.raw || got.folded !== want.folded ||
             got.prev !== want.prev || got.change !== want.change) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("word mismatch: expected kind=%0d raw=%h folded=%h prev=%h change=%h",
                        want.kind, want.raw, want.folded, want.prev, want.change);
               $display("               actual   kind=%0d raw=%h folded=%h prev=%h change=%h",
                        got.kind, got.raw, got.folded, got.prev, got.change);
            end
         end
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes into the deframer under random sender and receiver
// idling, rewrites sync word and fold threshold between phases, and checks
// every reported position and index word against the word scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swd_pkg::*;
   import deframer_check_pkg::*;

   localparam int STALL_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_BYTES   = 120;
   localparam int RANDOM_PHASES = 9;

   logic           clock = 1'b0;
   logic           reset;
   int unsigned    tx_idle_pct;
   int unsigned    rx_idle_pct;
   int unsigned    stall_cycles = 0;
   int unsigned    bytes_sent;
   word_scoreboard words;

   swd_req_if req_bus ();
   swd_rsp_if rsp_bus ();
   swd_csr_if csr_bus ();

   sync_word_feedback_deframer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      word_report_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind   = field_kind_type'(rsp_bus.field_kind);
         got.raw    = rsp_bus.raw_value;
         got.folded = rsp_bus.folded_value;
         got.prev   = rsp_bus.previous_value;
         got.change = rsp_bus.index_change;
         words.check_word(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words.note_rx_byte(value);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [WORD_W-1:0] value);
      for (int i = 3; i >= 0; i--) send_byte(value[i*BYTE_W +: BYTE_W]);
   endtask

   // Drop valid, drain every predicted word, then let the pipeline go quiet.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (words.expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [WORD_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      words.write_register(index, value);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return SENTINEL_UNSET;
         3:       return HOLD_AFTER_USE;
         4:       return words.fold_threshold;
         5:       return words.fold_threshold + 1'b1;
         6:       return 32'h8000_0000;
         7:       return words.index_now ^ 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_frame();
      int unsigned       noise;
      int unsigned       cut;
      logic [2*WORD_W-1:0] payload;
      noise = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
      repeat (noise) send_byte(BYTE_W'($urandom_range(255)));
      if (words.hunt_window != words.sync_word)
         send_word(words.sync_word);
      payload = {pick_word(), pick_word()};
      cut = ($urandom_range(9) == 0) ? $urandom_range(7, 1) : 8;
      for (int i = 0; i < cut; i++) send_byte(payload[2*WORD_W-1 - i*BYTE_W -: BYTE_W]);
   endtask

   initial begin
      logic [WORD_W-1:0] sync_choice;
      logic [WORD_W-1:0] thr_choice;
      words = new();
      tx_idle_pct = 21;
      rx_idle_pct = 65;
      bytes_sent  = 0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_SYNC_WORD;
      csr_bus.data    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(SYNC_WORD_RESET);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(SYNC_WORD_RESET);
      send_byte(8'h80);
      send_byte(8'h00);
      settle();
      // hold the partial position word across a new sync word
      write_csr(CSR_SYNC_WORD, 32'h00FF_FFFF);
      write_csr(CSR_FOLD_THRESHOLD, 32'hFFFF_FFFF);
      send_word(32'h00FF_FFFF);
      send_byte(8'h00);
      send_byte(8'h00);
      send_word(32'h7FFF_FFFF);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         if (phase == 3) begin
            tx_idle_pct = 65;
            rx_idle_pct = 21;
         end else if (phase == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         sync_choice = ($urandom_range(3) == 0) ? SYNC_WORD_RESET : $urandom();
         case ($urandom_range(3))
            0:       thr_choice = FOLD_THR_RESET;
            1:       thr_choice = $urandom();
            2:       thr_choice = $urandom_range(32'h0002_0000);
            default: thr_choice = $urandom() >> $urandom_range(31);
         endcase
         if (phase == 0) begin
            sync_choice = '0;
            thr_choice  = '0;
         end else if (phase == 1) begin
            sync_choice = '1;
            thr_choice  = '1;
         end
         write_csr(CSR_SYNC_WORD, sync_choice);
         write_csr(CSR_FOLD_THRESHOLD, thr_choice);
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) send_frame();
      end
      settle();

      if (words.mismatches == 0 && words.expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
